FILE: rtl/core/udp_ipv4_encapsulator_assert.svh
// ----------------------------------------------------------------------------
// udp_ipv4_encapsulator assertion macros
// Shared clocked assertion forms for the encapsulator checks.
// ----------------------------------------------------------------------------
`ifndef UDP_IPV4_ENCAPSULATOR_ASSERT_SVH
`define UDP_IPV4_ENCAPSULATOR_ASSERT_SVH

// clocked property, off while reset is asserted
`define UDPENC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("udp_ipv4_encapsulator check failed");

// same, as an implication
`define UDPENC_ASSERT_IMPL(label, ante, cons) \
    `UDPENC_ASSERT(label, (ante) |-> (cons))

`endif

FILE: rtl/core/udpenc_pkg.sv
// ----------------------------------------------------------------------------
// udpenc_pkg
// Types, constants and checksum helpers for the IPv4/UDP encapsulator.
// ----------------------------------------------------------------------------
package udpenc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_SOURCE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_DEST_ADDRESS   = 2'd1;
    localparam logic [1:0] REG_SOURCE_PORT    = 2'd2;
    localparam logic [1:0] REG_DEST_PORT      = 2'd3;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_HEADER  = 1'b1;

    localparam int unsigned LEN_W = 16;

    // version/ihl 0x4500 plus ttl/protocol 0x4011
    localparam logic [15:0] IP_FIXED_SUM  = 16'h8511;
    localparam logic [15:0] UDP_PROTOCOL  = 16'h0011;
    localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } cfg_t;

    // running datagram totals handed to the header builder
    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic [15:0]      sum;
        logic             ovf;
    } hdr_in_t;

    typedef struct packed {
        logic [15:0] ip_len;
        logic [15:0] ip_csum;
        logic [15:0] udp_len;
        logic [15:0] udp_csum;
        logic        ovf;
    } hdr_out_t;

    // end-around-carry add of two 16-bit words
    function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // fold a wide sum of 16-bit words to a 16-bit ones'-complement sum
    function automatic logic [15:0] oc_fold20(input logic [19:0] x);
        logic [16:0] t;
        t = {1'b0, x[15:0]} + {13'd0, x[19:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

FILE: rtl/core/udpenc_hdr.sv
// ----------------------------------------------------------------------------
// udpenc_hdr
// Builds IPv4/UDP lengths and both checksums from the datagram totals.
// ----------------------------------------------------------------------------
module udpenc_hdr
    import udpenc_pkg::*;
(
    input  cfg_t     cfg,
    input  hdr_in_t  hdr_in,
    output hdr_out_t hdr_out
);

    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [19:0] ip_raw;
    logic [19:0] udp_raw;
    logic [15:0] ip_sum;
    logic [15:0] udp_sum;
    logic [15:0] udp_csum;

    // lengths, no wrap since count never passes the payload limit
    assign ip_len  = hdr_in.count + IP_HDR_BYTES + UDP_HDR_BYTES;
    assign udp_len = hdr_in.count + UDP_HDR_BYTES;

    // ipv4 header sum, checksum and id fields are zero
    assign ip_raw = 20'(IP_FIXED_SUM) + 20'(ip_len)
                  + 20'(cfg.src_addr[31:16]) + 20'(cfg.src_addr[15:0])
                  + 20'(cfg.dst_addr[31:16]) + 20'(cfg.dst_addr[15:0]);

    // pseudo-header, udp header (length counted twice) and payload
    assign udp_raw = 20'(hdr_in.sum)
                   + 20'(cfg.src_addr[31:16]) + 20'(cfg.src_addr[15:0])
                   + 20'(cfg.dst_addr[31:16]) + 20'(cfg.dst_addr[15:0])
                   + 20'(UDP_PROTOCOL) + 20'(udp_len) + 20'(udp_len)
                   + 20'(cfg.src_port) + 20'(cfg.dst_port);

    assign ip_sum  = oc_fold20(ip_raw);
    assign udp_sum = oc_fold20(udp_raw);

    // a zero udp checksum goes out as all ones
    assign udp_csum = (udp_sum == 16'hFFFF) ? 16'hFFFF : ~udp_sum;

    assign hdr_out.ip_len   = ip_len;
    assign hdr_out.ip_csum  = ~ip_sum;
    assign hdr_out.udp_len  = udp_len;
    assign hdr_out.udp_csum = udp_csum;
    assign hdr_out.ovf      = hdr_in.ovf;

endmodule

FILE: rtl/core/udp_ipv4_encapsulator.sv
// ----------------------------------------------------------------------------
// udp_ipv4_encapsulator
// Passes UDP payload bytes through and appends an IPv4/UDP header summary.
// ----------------------------------------------------------------------------
// Accepts one payload byte per cycle unless in_stall is high (receiver stall
// or a pending header word). Every byte comes out as a payload word; the byte
// flagged last also produces a header word with both lengths and both
// checksums, so a datagram of N bytes yields N+1 words. The single result
// register carries one word per cycle unless the receiver stalls; the running
// ones'-complement sum is one 16-bit add per byte. Bytes past MAX_PAYLOAD are
// passed through but not counted or summed, and the header word then reports
// oversize. Write the addresses and ports only while no datagram is in flight.
module udp_ipv4_encapsulator
    import udpenc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1500
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [15:0] ip_total_length,
    output logic [15:0] ip_header_checksum,
    output logic [15:0] udp_length,
    output logic [15:0] udp_checksum,
    output logic        oversize,
    output logic        end_of_packet
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    // configuration registers
    cfg_t cfg_reg;

    // running datagram state
    logic [LEN_W-1:0] count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic             odd_reg, odd_next;
    logic             ovf_reg, ovf_next;

    // input stage
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_hdr_reg, s1_hdr_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;
    hdr_in_t          s1_tot_reg;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg;
    logic [7:0]       out_byte_reg;
    hdr_out_t         out_hdr_reg;

    logic             in_accept;
    logic             out_load;
    logic             s1_final;
    logic             s1_free;
    logic             counted;
    logic [LEN_W-1:0] count_upd;
    logic [15:0]      sum_upd;
    logic             odd_upd;
    logic             ovf_upd;
    logic [15:0]      byte_word;
    hdr_in_t          tot_upd;
    hdr_out_t         hdr_built;

    assign cfg_ready = 1'b1;

    // handshake flow
    assign out_load  = !out_valid_reg || !out_stall;
    assign s1_final  = !s1_last_reg || s1_hdr_reg;
    assign s1_free   = !s1_valid_reg || (out_load && s1_final);
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && !in_stall;

    // byte accumulate, first byte of a pair is the high half
    assign counted   = count_reg < MAX_LEN;
    assign byte_word = odd_reg ? {8'd0, payload_byte} : {payload_byte, 8'd0};
    assign count_upd = counted ? count_reg + LEN_W'(1) : count_reg;
    assign sum_upd   = counted ? oc_add16(sum_reg, byte_word) : sum_reg;
    assign odd_upd   = counted ? !odd_reg : odd_reg;
    assign ovf_upd   = counted ? ovf_reg : 1'b1;

    assign tot_upd.count = count_upd;
    assign tot_upd.sum   = sum_upd;
    assign tot_upd.ovf   = ovf_upd;

    // datagram state, cleared after the last byte
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        odd_next   = odd_reg;
        ovf_next   = ovf_reg;
        if (in_accept)
        begin
            if (last_byte)
            begin
                count_next = '0;
                sum_next   = '0;
                odd_next   = 1'b0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = count_upd;
                sum_next   = sum_upd;
                odd_next   = odd_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    // input stage control, header phase follows the payload word
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_hdr_next   = s1_hdr_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
            s1_hdr_next   = 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_next = 1'b0;
            s1_hdr_next   = 1'b0;
        end
        else if (out_load)
        begin
            s1_hdr_next = 1'b1;
        end
    end

    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    udpenc_hdr u_hdr (
        .cfg     (cfg_reg),
        .hdr_in  (s1_tot_reg),
        .hdr_out (hdr_built)
    );

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            odd_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_hdr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_ADDRESS: cfg_reg.src_addr <= cfg_data;
                    REG_DEST_ADDRESS:   cfg_reg.dst_addr <= cfg_data;
                    REG_SOURCE_PORT:    cfg_reg.src_port <= cfg_data[15:0];
                    REG_DEST_PORT:      cfg_reg.dst_port <= cfg_data[15:0];
                    default:            cfg_reg <= cfg_reg;
                endcase
            end
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            odd_reg       <= odd_next;
            ovf_reg       <= ovf_next;
            s1_valid_reg  <= s1_valid_next;
            s1_hdr_reg    <= s1_hdr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= payload_byte;
            s1_last_reg <= last_byte;
            s1_tot_reg  <= tot_upd;
        end
        if (out_load && s1_valid_reg)
        begin
            if (s1_hdr_reg)
            begin
                out_kind_reg <= KIND_HEADER;
                out_byte_reg <= '0;
                out_hdr_reg  <= hdr_built;
            end
            else
            begin
                out_kind_reg <= KIND_PAYLOAD;
                out_byte_reg <= s1_byte_reg;
                out_hdr_reg  <= '0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign kind               = out_kind_reg;
    assign data_byte          = out_byte_reg;
    assign ip_total_length    = out_hdr_reg.ip_len;
    assign ip_header_checksum = out_hdr_reg.ip_csum;
    assign udp_length         = out_hdr_reg.udp_len;
    assign udp_checksum       = out_hdr_reg.udp_csum;
    assign oversize           = out_hdr_reg.ovf;
    assign end_of_packet      = (out_kind_reg == KIND_HEADER);

endmodule

FILE: rtl/core/udpenc_chk.sv
// ----------------------------------------------------------------------------
// udpenc_chk
// Port-level checks for the IPv4/UDP encapsulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "udp_ipv4_encapsulator_assert.svh"

module udpenc_chk
    import udpenc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 1500
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [7:0]  data_byte,
    input logic [15:0] ip_total_length,
    input logic [15:0] udp_length,
    input logic [15:0] udp_checksum,
    input logic        oversize,
    input logic        end_of_packet
);

    // header word and end of packet go together
    `UDPENC_ASSERT_IMPL(a_eop_kind, out_valid, end_of_packet == (kind == KIND_HEADER))

    // ip length is udp length plus the ipv4 header, and the udp checksum is never zero
    `UDPENC_ASSERT_IMPL(a_len_rel, out_valid && kind == KIND_HEADER,
        ip_total_length == udp_length + IP_HDR_BYTES && udp_checksum != 16'd0)

    // oversize datagrams report the saturated length
    `UDPENC_ASSERT_IMPL(a_sat_len, out_valid && kind == KIND_HEADER && oversize,
        udp_length == 16'(MAX_PAYLOAD) + UDP_HDR_BYTES)

    // a stalled word holds
    `UDPENC_ASSERT(a_out_hold, out_valid && out_stall |=>
        out_valid && $stable(kind) && $stable(data_byte) && $stable(udp_checksum))

endmodule

bind udp_ipv4_encapsulator udpenc_chk #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_chk (.*);

FILE: tb/udp_ipv4_encapsulator_test.sv
// ----------------------------------------------------------------------------
// udp_ipv4_encapsulator_test
// Self-checking bench for the IPv4/UDP encapsulator. Payload bytes go in with
// random sender gaps and receiver stalls. A local model of the byte count and
// the ones'-complement sums predicts every pass-through word and every header
// word, and each word that comes out is compared in order against it.
// Addresses and ports are reloaded between phases, including all-zero and
// all-one settings. One datagram runs past the payload limit.
// ----------------------------------------------------------------------------
module udp_ipv4_encapsulator_test;
    import udpenc_pkg::*;

    localparam int unsigned MAX_PAYLOAD_BYTES = 1500;
    localparam int unsigned PHASE_BYTES       = 16;
    localparam int unsigned NUM_PHASES        = 6;
    localparam int unsigned OVERSIZE_PHASE    = 2;
    localparam int unsigned DRAIN_CYCLES      = 8;
    localparam int unsigned RESET_CYCLES      = 12;
    localparam int unsigned CYCLE_LIMIT       = 1000000;
    localparam int unsigned REPORT_MAX        = 10;
    localparam int unsigned DIR_ROWS          = 16;
    localparam int unsigned DIR_ONES_FROM     = 7;

    // fixed ipv4 header words: version/ihl, ttl 64 with protocol udp
    localparam logic [15:0] VER_IHL_WORD   = 16'h4500;
    localparam logic [15:0] TTL_PROTO_WORD = 16'h4011;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] ip_len;
        logic [15:0] ip_csum;
        logic [15:0] udp_len;
        logic [15:0] udp_csum;
        logic        ovf;
        logic        eop;
    } encap_word_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        is_last;
        logic        typed;
        logic [15:0] ip_len;
        logic [15:0] ip_csum;
        logic [15:0] udp_len;
        logic [15:0] udp_csum;
    } dir_row_t;

    // directed bytes; rows before DIR_ONES_FROM run with the reset settings,
    // the rest with every address and port bit set
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        // single zero byte
        '{8'h00, 1'b1, 1'b1, 16'h001D, 16'h7AD1, 16'h0009, 16'hFFDC},
        // single all-ones byte
        '{8'hFF, 1'b1, 1'b1, 16'h001D, 16'h7AD1, 16'h0009, 16'h00DC},
        // pair whose udp checksum comes out zero, sent as all ones
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hDA, 1'b1, 1'b1, 16'h001E, 16'h7AD0, 16'h000A, 16'hFFFF},
        // odd length, unpaired final byte
        '{8'h80, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h01, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h7F, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        // all-ones addresses and ports from here
        '{8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hAA, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h0F, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hF0, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h01, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] ip_total_length;
    logic [15:0] ip_header_checksum;
    logic [15:0] udp_length;
    logic [15:0] udp_checksum;
    logic        oversize;
    logic        end_of_packet;

    // local copy of the address and port registers
    logic [31:0] cf_src_addr;
    logic [31:0] cf_dst_addr;
    logic [15:0] cf_src_port;
    logic [15:0] cf_dst_port;

    // running datagram totals
    logic [15:0] dg_count;
    logic [15:0] dg_sum;
    logic        dg_low_next;
    logic        dg_over;

    encap_word_t pending_words[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pct;
    int unsigned gap_pct;
    bit          idle_on;

    udp_ipv4_encapsulator #(
        .MAX_PAYLOAD(MAX_PAYLOAD_BYTES)
    ) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .payload_byte      (payload_byte),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .data_byte         (data_byte),
        .ip_total_length   (ip_total_length),
        .ip_header_checksum(ip_header_checksum),
        .udp_length        (udp_length),
        .udp_checksum      (udp_checksum),
        .oversize          (oversize),
        .end_of_packet     (end_of_packet)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ones'-complement add with end-around carry
    function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] w);
        int unsigned s;
        s = acc + w;
        s = (s & 32'h0000_FFFF) + (s >> 16);
        return s[15:0];
    endfunction

    task automatic clear_datagram();
        dg_count    = '0;
        dg_sum      = '0;
        dg_low_next = 1'b0;
        dg_over     = 1'b0;
    endtask

    // predict the words one accepted byte produces
    task automatic account_byte(input logic [7:0] b, input logic is_last);
        encap_word_t w;
        logic [15:0] ipv;
        logic [15:0] usum;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        w      = '0;
        w.kind = KIND_PAYLOAD;
        w.data = b;
        pending_words.push_back(w);

        // bytes past the limit are passed on but not counted
        if (dg_count < MAX_PAYLOAD_BYTES)
        begin
            dg_count    = dg_count + 16'd1;
            dg_sum      = csum_add(dg_sum, dg_low_next ? {8'h00, b} : {b, 8'h00});
            dg_low_next = ~dg_low_next;
        end
        else
        begin
            dg_over = 1'b1;
        end

        if (is_last)
        begin
            ip_len  = dg_count + IP_HDR_BYTES + UDP_HDR_BYTES;
            udp_len = dg_count + UDP_HDR_BYTES;

            ipv = csum_add(VER_IHL_WORD, ip_len);
            ipv = csum_add(ipv, TTL_PROTO_WORD);
            ipv = csum_add(ipv, cf_src_addr[31:16]);
            ipv = csum_add(ipv, cf_src_addr[15:0]);
            ipv = csum_add(ipv, cf_dst_addr[31:16]);
            ipv = csum_add(ipv, cf_dst_addr[15:0]);

            // payload sum, then pseudo-header and udp header
            usum = csum_add(dg_sum, cf_src_addr[31:16]);
            usum = csum_add(usum, cf_src_addr[15:0]);
            usum = csum_add(usum, cf_dst_addr[31:16]);
            usum = csum_add(usum, cf_dst_addr[15:0]);
            usum = csum_add(usum, UDP_PROTOCOL);
            usum = csum_add(usum, udp_len);
            usum = csum_add(usum, cf_src_port);
            usum = csum_add(usum, cf_dst_port);
            usum = csum_add(usum, udp_len);

            w          = '0;
            w.kind     = KIND_HEADER;
            w.ip_len   = ip_len;
            w.ip_csum  = ~ipv;
            w.udp_len  = udp_len;
            w.udp_csum = (~usum == 16'h0000) ? 16'hFFFF : ~usum;
            w.ovf      = dg_over;
            w.eop      = 1'b1;
            pending_words.push_back(w);
            clear_datagram();
        end
    endtask

    // one payload word through the input channel, with an optional gap first
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= b;
        last_byte    <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        account_byte(b, is_last);
    endtask

    // one register write; valid is left high for back-to-back writes
    task automatic put_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_SOURCE_ADDRESS: cf_src_addr = val;
            REG_DEST_ADDRESS:   cf_dst_addr = val;
            REG_SOURCE_PORT:    cf_src_port = val[15:0];
            REG_DEST_PORT:      cf_dst_port = val[15:0];
            default:            ;
        endcase
    endtask

    task automatic load_config(input logic [31:0] sa, input logic [31:0] da,
                               input logic [31:0] sp, input logic [31:0] dp);
        put_reg(REG_SOURCE_ADDRESS, sa);
        put_reg(REG_DEST_ADDRESS, da);
        put_reg(REG_SOURCE_PORT, sp);
        put_reg(REG_DEST_PORT, dp);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every awaited word arrive, then let the bench drain
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register value: zero, all ones or random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random receiver stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            out_stall  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin : word_check
        encap_word_t got;
        encap_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, data_byte, ip_total_length, ip_header_checksum,
                   udp_length, udp_checksum, oversize, end_of_packet};
            if (pending_words.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected word: kind=%0d data=%h iplen=%h udplen=%h",
                             got.kind, got.data, got.ip_len, got.udp_len);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got !== want)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < REPORT_MAX)
                    begin
                        $display("word mismatch at cycle %0d", cycle_count);
                        $display("  expected kind=%0d data=%h iplen=%h ipcs=%h",
                                 want.kind, want.data, want.ip_len, want.ip_csum,
                                 " udplen=%h udpcs=%h ovf=%0d eop=%0d",
                                 want.udp_len, want.udp_csum, want.ovf, want.eop);
                        $display("  actual   kind=%0d data=%h iplen=%h ipcs=%h",
                                 got.kind, got.data, got.ip_len, got.ip_csum,
                                 " udplen=%h udpcs=%h ovf=%0d eop=%0d",
                                 got.udp_len, got.udp_csum, got.ovf, got.eop);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("udp_ipv4_encapsulator_test: FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned p;
        int unsigned n;
        int unsigned len;
        int unsigned sent;
        int unsigned i;
        dir_row_t    row;
        encap_word_t hw;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_SOURCE_ADDRESS;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        payload_byte <= '0;
        last_byte    <= 1'b0;
        idle_on      = 1'b1;
        gap_pct      = 20;
        stall_pct    = 20;
        cf_src_addr  = '0;
        cf_dst_addr  = '0;
        cf_src_port  = '0;
        cf_dst_port  = '0;
        clear_datagram();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; typed-in header values replace the predicted ones
        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            if (i == DIR_ONES_FROM)
            begin
                settle();
                load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end
            send_byte(row.data, row.is_last);
            if (row.typed)
            begin
                hw          = pending_words.pop_back();
                hw.ip_len   = row.ip_len;
                hw.ip_csum  = row.ip_csum;
                hw.udp_len  = row.udp_len;
                hw.udp_csum = row.udp_csum;
                pending_words.push_back(hw);
            end
        end

        // random datagrams, new addresses and ports per phase, no idling at the end
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            if (p == 1)
                load_config(32'h0, 32'h0, 32'h0, 32'h0);
            else
                load_config(pick_value(), pick_value(), pick_value(), pick_value());
            idle_on   = (p != NUM_PHASES - 1);
            stall_pct = $urandom_range(0, 3) * 10;
            sent      = 0;
            while (sent < PHASE_BYTES)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
                    6, 7, 8:          len = $urandom_range(9, 48);
                    default:          len = $urandom_range(49, 200);
                endcase
                // one datagram past the payload limit
                if (p == OVERSIZE_PHASE && sent == 0)
                    len = MAX_PAYLOAD_BYTES + $urandom_range(1, 6);
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 8;
                    default: gap_pct = 35;
                endcase
                for (n = 0; n < len; n++)
                    send_byte(8'($urandom_range(0, 255)), n == len - 1);
                sent = sent + len;
            end
        end

        settle();
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("udp_ipv4_encapsulator_test: PASS");
        else
            $display("udp_ipv4_encapsulator_test: FAIL");
        $finish;
    end

endmodule
